>>> rtl/ede_pkg.sv
// ----------------------------------------------------------------------------
// ede_pkg - shared types and constants of the edit distance engine
// sizes of the cell row, item codes and the wavefront token carried cell to cell
// ----------------------------------------------------------------------------
package ede_pkg;

    localparam int MAX_LEN = 512;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int COST_W  = LEN_W;
    localparam int CNT_W   = $clog2(MAX_LEN + 2);
    localparam int SYM_W   = 8;
    localparam int MODE_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_CONSUME = 2'd2,
        MODE_FINISH  = 2'd3
    } t_mode;

    // one source byte walking down the row: new cost of the left neighbor
    // and its cost from the previous row
    typedef struct packed {
        logic              valid;
        logic [SYM_W-1:0]  sym;
        logic [COST_W-1:0] left;
        logic [COST_W-1:0] diag;
    } t_tok;

    // broadcast from the control to every cell
    typedef struct packed {
        logic             clear;
        logic             append;
        logic [SYM_W-1:0] sym;
    } t_bcast;

endpackage

>>> rtl/ede_cell.sv
// ----------------------------------------------------------------------------
// ede_cell - one column of the distance table
// holds one target byte and its cost entry, updates it as a source token passes
// ----------------------------------------------------------------------------
module ede_cell
    import ede_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [COST_W-1:0] i_init,
    input  t_bcast            i_bc,
    input  logic              i_prev_used,
    input  t_tok              i_tok,
    output logic              o_used,
    output t_tok              o_tok
);

    logic [SYM_W-1:0]  r_byte;
    logic [COST_W-1:0] r_cost;
    logic              r_used;
    t_tok              r_tok;

    logic [COST_W-1:0] w_min_a;
    logic [COST_W-1:0] w_min;
    logic [COST_W-1:0] w_next;

    always_comb begin
        w_min_a = (i_tok.diag < r_cost) ? i_tok.diag : r_cost;
        w_min   = (w_min_a < i_tok.left) ? w_min_a : i_tok.left;
        w_next  = (r_byte == i_tok.sym) ? i_tok.diag : (w_min + COST_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_bc.clear) begin
            r_used      <= 1'b0;
            r_cost      <= i_init;
            r_tok.valid <= 1'b0;
        end else begin
            // first free cell behind the last used one takes the byte
            if (i_bc.append && !r_used && i_prev_used) begin
                r_byte <= i_bc.sym;
                r_used <= 1'b1;
            end
            r_tok.valid <= i_tok.valid;
            r_tok.sym   <= i_tok.sym;
            if (i_tok.valid && r_used) begin
                r_cost     <= w_next;
                r_tok.left <= w_next;
                r_tok.diag <= r_cost;
            end else begin
                // past the end of the target the token just travels on
                r_tok.left <= i_tok.left;
                r_tok.diag <= i_tok.diag;
            end
        end
    end

    assign o_used = r_used;
    assign o_tok  = r_tok;

endmodule

>>> rtl/ede_row.sv
// ----------------------------------------------------------------------------
// ede_row - the row of cells
// chains MAX_LEN cells; tokens enter at cell 1 and leave after the last cell
// ----------------------------------------------------------------------------
module ede_row
    import ede_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_bcast i_bc,
    input  t_tok   i_tok,
    output t_tok   o_tok
);

    t_tok w_tok  [MAX_LEN+1];
    logic w_used [MAX_LEN+1];

    assign w_tok[0]  = i_tok;
    assign w_used[0] = 1'b1;

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        ede_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_init      (COST_W'(j + 1)),
            .i_bc        (i_bc),
            .i_prev_used (w_used[j]),
            .i_tok       (w_tok[j]),
            .o_used      (w_used[j+1]),
            .o_tok       (w_tok[j+1])
        );
    end

    assign o_tok = w_tok[MAX_LEN];

endmodule

>>> rtl/edit_distance_engine_top.sv
// ----------------------------------------------------------------------------
// edit_distance_engine_top - Levenshtein distance engine
// unit-cost edit distance between a stored target and a streamed source
// ----------------------------------------------------------------------------
// usage:
//   an item (i_mode, i_symbol) is taken at a rising edge with i_start high and
//   o_busy low. clear starts a new pair, append stores a target byte, consume
//   runs one source byte against the whole target, finish reports.
//   every item but finish leaves o_busy low, so appends and consumes may
//   follow each other back to back.
//   a consumed byte travels down a row of MAX_LEN cells as a wavefront token,
//   one cell per cycle; several source bytes are in the row at once.
//   finish raises o_busy until every token has left the row, then shows
//   o_distance and o_overflow for one cycle with o_valid high. the wait
//   after a consume is set by the length of the cell row.
//   the receiver cannot stall; each result stands for exactly one cycle.
//   reset (synchronous, active low) or a clear item empties both strings,
//   drops tokens in flight and clears the overflow flag.
// ----------------------------------------------------------------------------
module edit_distance_engine_top
    import ede_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [SYM_W-1:0]  i_symbol,
    output logic              o_busy,
    output logic              o_valid,
    output logic [LEN_W-1:0]  o_distance,
    output logic              o_overflow
);

    // pair bookkeeping
    logic [LEN_W-1:0]  r_tgt_len;
    logic [LEN_W-1:0]  r_src_len;
    logic              r_ovf;
    // cost of the last target column, kept up to date as tokens leave the row
    logic [COST_W-1:0] r_dist;
    // tokens between launch and the end of the row
    logic [CNT_W-1:0]  r_inflight;
    logic [CNT_W-1:0]  n_inflight;
    logic              r_fin_wait;
    t_tok              r_launch;

    logic              r_valid;
    logic [LEN_W-1:0]  r_distance;
    logic              r_overflow;

    logic              w_accept;
    logic              w_launch;
    t_mode             w_mode;
    t_bcast            w_bc;
    t_tok              w_end;

    assign w_accept = i_start && !r_fin_wait;
    assign w_mode   = t_mode'(i_mode);
    // source byte that still fits starts a new wavefront
    assign w_launch = w_accept && (w_mode == MODE_CONSUME)
                      && (r_src_len != LEN_W'(MAX_LEN));

    // target bytes only before the first source byte of a pair
    assign w_bc.clear  = w_accept && (w_mode == MODE_CLEAR);
    assign w_bc.append = w_accept && (w_mode == MODE_APPEND) && (r_src_len == '0);
    assign w_bc.sym    = i_symbol;

    assign n_inflight = r_inflight + CNT_W'(w_launch) - CNT_W'(w_end.valid);

    ede_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bc    (w_bc),
        .i_tok   (r_launch),
        .o_tok   (w_end)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_len      <= '0;
            r_src_len      <= '0;
            r_ovf          <= 1'b0;
            r_dist         <= '0;
            r_inflight     <= '0;
            r_fin_wait     <= 1'b0;
            r_launch.valid <= 1'b0;
            r_valid        <= 1'b0;
        end else begin
            r_valid        <= 1'b0;
            r_launch.valid <= 1'b0;
            r_inflight     <= n_inflight;

            // token leaving the row carries the new cost of the last column
            if (w_end.valid) begin
                r_dist <= w_end.left;
            end

            // report once the row has drained
            if (r_fin_wait && (r_inflight == '0)) begin
                r_valid    <= 1'b1;
                r_distance <= r_dist;
                r_overflow <= r_ovf;
                r_fin_wait <= 1'b0;
            end

            if (w_accept) begin
                case (w_mode)
                    MODE_CLEAR: begin
                        r_tgt_len  <= '0;
                        r_src_len  <= '0;
                        r_ovf      <= 1'b0;
                        r_dist     <= '0;
                        r_inflight <= '0;
                    end
                    MODE_APPEND: begin
                        if (r_src_len == '0) begin
                            if (r_tgt_len == LEN_W'(MAX_LEN)) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_tgt_len <= r_tgt_len + LEN_W'(1);
                                r_dist    <= r_tgt_len + LEN_W'(1);
                            end
                        end
                    end
                    MODE_CONSUME: begin
                        if (r_src_len == LEN_W'(MAX_LEN)) begin
                            r_ovf <= 1'b1;
                        end else begin
                            // column zero: old cost is the source length
                            r_launch.valid <= 1'b1;
                            r_launch.sym   <= i_symbol;
                            r_launch.diag  <= r_src_len;
                            r_launch.left  <= r_src_len + LEN_W'(1);
                            r_src_len      <= r_src_len + LEN_W'(1);
                        end
                    end
                    MODE_FINISH: begin
                        r_fin_wait <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_busy     = r_fin_wait;
    assign o_valid    = r_valid;
    assign o_distance = r_distance;
    assign o_overflow = r_overflow;

    // two results never stand in adjacent cycles
    a_no_double_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for two cycles");

    // a token can only leave the row if it was counted in
    a_end_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end.valid |-> (r_inflight != '0))
        else $error("token left the row without being counted");

    // nothing is in flight before the first source byte of a pair
    a_no_tokens_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_src_len == '0) |-> (r_inflight == '0))
        else $error("tokens in flight with no source byte consumed");

    // the count never exceeds the row plus the launch stage
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(MAX_LEN + 1))
        else $error("in-flight count out of range");

endmodule
